@@ rtl/alfe_pkg.sv @@
// ----------------------------------------------------------------------------
// alfe_pkg
// Shared types and constants of the addressable LED frame encoder.
// ----------------------------------------------------------------------------
package alfe_pkg;

    // One LED word as taken on the input channel.
    typedef struct packed {
        logic        cmd;          // 0 packed rgb, 1 hue angle
        logic [23:0] packed_color;
        logic [8:0]  hue_angle;
        logic [8:0]  brightness;
    } t_led_item;

    // Color source codes
    localparam logic CMD_PACKED = 1'b0;
    localparam logic CMD_HUE    = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_ONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_ZERO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_SLOTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 3'd3;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CODE_W     = 16;
    localparam int unsigned COUNT_W    = 11;
    localparam int unsigned GRB_W      = 24;

    localparam logic [CODE_W-1:0]  CODE_ONE_RST  = 16'd60;
    localparam logic [CODE_W-1:0]  CODE_ZERO_RST = 16'd30;
    localparam logic [COUNT_W-1:0] LED_COUNT_RST = 11'd64;

    // Brightness full scale
    localparam logic [8:0] BRIGHT_FULL = 9'd256;

    // Hue wheel
    localparam logic [8:0] HUE_SECTOR = 9'd60;
    localparam logic [8:0] HUE_LIMIT  = 9'd360;

    // floor(y / 60) == (y * RECIP_60) >> RECIP_SHIFT for y < 16384
    localparam logic [14:0] RECIP_60    = 15'd17477;
    localparam int unsigned RECIP_SHIFT = 20;

endpackage

@@ rtl/alfe_color.sv @@
// ----------------------------------------------------------------------------
// alfe_color
// Color unit: brightness scaling and hue wheel on one shared multiplier,
// four multiply steps per LED word.
// ----------------------------------------------------------------------------
module alfe_color (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  alfe_pkg::t_led_item  i_item,
    output logic                 o_done,
    output logic [23:0]          o_grb
);

    typedef enum logic [2:0] {
        SEC_R2Y = 3'd0,   // R full, G rise
        SEC_Y2G = 3'd1,   // R fall, G full
        SEC_G2C = 3'd2,   // G full, B rise
        SEC_C2B = 3'd3,   // G fall, B full
        SEC_B2M = 3'd4,   // R rise, B full
        SEC_M2R = 3'd5    // R full, B fall
    } t_sector;

    logic        r_busy;
    logic [1:0]  r_step;
    logic        r_done;

    logic        r_cmd;
    logic [23:0] r_pk;
    logic [5:0]  r_t;
    t_sector     r_sector;
    logic        r_black;
    logic [8:0]  r_b;
    logic [7:0]  r_red, r_grn, r_blu;
    logic [13:0] r_y_rise, r_y_fall;
    logic [7:0]  r_rise, r_fall;

    logic [8:0]  s_b_sat;
    t_sector     s_sector;
    logic [8:0]  s_base;
    logic [13:0] s_op_a;
    logic [14:0] s_op_b;
    logic [28:0] s_prod;
    logic [21:0] s_x255;
    logic [13:0] s_y;
    logic [16:0] s_full_w;
    logic [7:0]  s_full;
    logic [7:0]  s_r, s_g, s_bl;

    // saturate brightness, locate hue sector
    assign s_b_sat = (i_item.brightness > alfe_pkg::BRIGHT_FULL) ?
                     alfe_pkg::BRIGHT_FULL : i_item.brightness;

    always_comb begin
        if (i_item.hue_angle < alfe_pkg::HUE_SECTOR) begin
            s_sector = SEC_R2Y;
            s_base   = 9'd0;
        end else if (i_item.hue_angle < 9'd120) begin
            s_sector = SEC_Y2G;
            s_base   = 9'd60;
        end else if (i_item.hue_angle < 9'd180) begin
            s_sector = SEC_G2C;
            s_base   = 9'd120;
        end else if (i_item.hue_angle < 9'd240) begin
            s_sector = SEC_C2B;
            s_base   = 9'd180;
        end else if (i_item.hue_angle < 9'd300) begin
            s_sector = SEC_B2M;
            s_base   = 9'd240;
        end else begin
            s_sector = SEC_M2R;
            s_base   = 9'd300;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_step)
            2'd0: begin
                s_op_a = (r_cmd == alfe_pkg::CMD_HUE) ? 14'(r_t) : 14'(r_pk[23:16]);
                s_op_b = 15'(r_b);
            end
            2'd1: begin
                s_op_a = (r_cmd == alfe_pkg::CMD_HUE) ?
                         14'(alfe_pkg::HUE_SECTOR[5:0] - r_t) : 14'(r_pk[15:8]);
                s_op_b = 15'(r_b);
            end
            2'd2: begin
                s_op_a = (r_cmd == alfe_pkg::CMD_HUE) ? r_y_rise : 14'(r_pk[7:0]);
                s_op_b = (r_cmd == alfe_pkg::CMD_HUE) ? alfe_pkg::RECIP_60 : 15'(r_b);
            end
            2'd3: begin
                s_op_a = r_y_fall;
                s_op_b = alfe_pkg::RECIP_60;
            end
            default: begin
                s_op_a = '0;
                s_op_b = '0;
            end
        endcase
    end

    assign s_prod = 29'(s_op_a) * 29'(s_op_b);

    // 255*m / 256, m = t*b fits 14 bits
    assign s_x255 = {s_prod[13:0], 8'd0} - 22'(s_prod[13:0]);
    assign s_y    = s_x255[21:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmd    <= i_item.cmd;
            r_pk     <= i_item.packed_color;
            r_b      <= s_b_sat;
            r_sector <= s_sector;
            r_t      <= 6'(i_item.hue_angle - s_base);
            r_black  <= (i_item.hue_angle >= alfe_pkg::HUE_LIMIT);
        end else if (r_busy) begin
            case (r_step)
                2'd0: begin
                    if (r_cmd == alfe_pkg::CMD_HUE) r_y_rise <= s_y;
                    else r_red <= s_prod[15:8];
                end
                2'd1: begin
                    if (r_cmd == alfe_pkg::CMD_HUE) r_y_fall <= s_y;
                    else r_grn <= s_prod[15:8];
                end
                2'd2: begin
                    if (r_cmd == alfe_pkg::CMD_HUE)
                        r_rise <= s_prod[alfe_pkg::RECIP_SHIFT +: 8];
                    else r_blu <= s_prod[15:8];
                end
                2'd3: begin
                    if (r_cmd == alfe_pkg::CMD_HUE)
                        r_fall <= s_prod[alfe_pkg::RECIP_SHIFT +: 8];
                end
                default: begin
                end
            endcase
        end
    end

    // 255*b/256
    assign s_full_w = {r_b, 8'd0} - 17'(r_b);
    assign s_full   = s_full_w[15:8];

    always_comb begin
        s_r  = 8'd0;
        s_g  = 8'd0;
        s_bl = 8'd0;
        if (r_cmd == alfe_pkg::CMD_PACKED) begin
            s_r  = r_red;
            s_g  = r_grn;
            s_bl = r_blu;
        end else if (!r_black) begin
            case (r_sector)
                SEC_R2Y: begin s_r = s_full; s_g  = r_rise; end
                SEC_Y2G: begin s_r = r_fall; s_g  = s_full; end
                SEC_G2C: begin s_g = s_full; s_bl = r_rise; end
                SEC_C2B: begin s_g = r_fall; s_bl = s_full; end
                SEC_B2M: begin s_r = r_rise; s_bl = s_full; end
                SEC_M2R: begin s_r = s_full; s_bl = r_fall; end
                default: begin end
            endcase
        end
    end

    assign o_grb  = {s_g, s_r, s_bl};
    assign o_done = r_done;

endmodule

@@ rtl/addressable_led_frame_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// addressable_led_frame_encoder_unit
// Turns one LED color word into a run of timer compare codes: G, R, B MSB
// first, a trailing zero slot, and a reset-gap word ahead of each frame.
// ----------------------------------------------------------------------------
// Flow: a new LED word is taken only in idle, once the four-step color
//   multiplier has run and the trailing slot word of the previous LED
//   is loaded; slot words leave at one output word per cycle while the
//   sink is ready.
// Reset: synchronous, active low; config registers return to their
//   defaults, no frame is open and the LED position is zero.
// ----------------------------------------------------------------------------
module addressable_led_frame_encoder_unit #(
    parameter int unsigned MAX_LEDS     = 1024,
    parameter int unsigned BITS_PER_LED = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [alfe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [alfe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // LED color words in
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [23:0]                       i_packed_color,
    input  logic [8:0]                        i_hue_angle,
    input  logic [8:0]                        i_brightness,
    // slot words out
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [15:0]                       o_pulse_code,
    output logic                              o_reset_gap,
    output logic                              o_last_of_led,
    output logic                              o_frame_done
);

    localparam int unsigned POS_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int unsigned CMP_W  = (POS_W + 1 > alfe_pkg::COUNT_W) ?
                                     POS_W + 1 : alfe_pkg::COUNT_W;
    localparam int unsigned SLOT_W = $clog2(BITS_PER_LED + 1);
    localparam logic [CMP_W-1:0]  MAX_CNT   = CMP_W'(MAX_LEDS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BITS_PER_LED);

    // sequencer: wait for word, run color unit, stream slots
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_COLOR = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    t_state r_state;

    logic [alfe_pkg::CODE_W-1:0]  r_code_one;
    logic [alfe_pkg::CODE_W-1:0]  r_code_zero;
    logic [alfe_pkg::COUNT_W-1:0] r_led_count;

    logic [POS_W-1:0]  r_led_pos;
    logic              r_frame_open;
    logic              r_gap_pend;
    logic [SLOT_W-1:0] r_slot;
    logic [alfe_pkg::GRB_W-1:0] r_grb;

    logic        r_out_valid;
    logic [15:0] r_pulse_code;
    logic        r_reset_gap;
    logic        r_last_of_led;
    logic        r_frame_done;

    alfe_pkg::t_led_item s_item;
    logic        s_start;
    logic        s_color_done;
    logic [23:0] s_grb;
    logic        s_load;
    logic [CMP_W-1:0] s_cnt_ext;
    logic [CMP_W-1:0] s_cnt;
    logic [CMP_W-1:0] s_pos_next;
    logic        s_led_done;

    assign o_in_ready = (r_state == ST_IDLE);
    assign s_start    = i_in_valid && o_in_ready;

    assign s_item.cmd          = i_cmd;
    assign s_item.packed_color = i_packed_color;
    assign s_item.hue_angle    = i_hue_angle;
    assign s_item.brightness   = i_brightness;

    alfe_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_item  (s_item),
        .o_done  (s_color_done),
        .o_grb   (s_grb)
    );

    // Config registers. Nothing is held here for reset_slots, so a write to
    // it is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_one  <= alfe_pkg::CODE_ONE_RST;
            r_code_zero <= alfe_pkg::CODE_ZERO_RST;
            r_led_count <= alfe_pkg::LED_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                alfe_pkg::REG_CODE_ONE:    r_code_one  <= i_cfg_data;
                alfe_pkg::REG_CODE_ZERO:   r_code_zero <= i_cfg_data;
                alfe_pkg::REG_RESET_SLOTS: begin end
                alfe_pkg::REG_LED_COUNT:
                    r_led_count <= i_cfg_data[alfe_pkg::COUNT_W-1:0];
                default: begin end
            endcase
        end
    end

    // Frame length clamp: zero acts as one, above MAX_LEDS acts as MAX_LEDS.
    assign s_cnt_ext = CMP_W'(r_led_count);
    always_comb begin
        if (s_cnt_ext == '0)          s_cnt = CMP_W'(1);
        else if (s_cnt_ext > MAX_CNT) s_cnt = MAX_CNT;
        else                          s_cnt = s_cnt_ext;
    end
    assign s_pos_next = CMP_W'(r_led_pos) + CMP_W'(1);
    assign s_led_done = (s_pos_next >= s_cnt);

    // output register free or being drained this cycle
    assign s_load = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_frame_open <= 1'b0;
            r_gap_pend   <= 1'b0;
            r_led_pos    <= '0;
            r_slot       <= '0;
        end else begin
            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_start) r_state <= ST_COLOR;
                end
                ST_COLOR: begin
                    if (s_color_done) begin
                        r_gap_pend   <= !r_frame_open;
                        r_frame_open <= 1'b1;
                        r_slot       <= '0;
                        r_state      <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (s_load) begin
                        if (r_gap_pend) begin
                            r_gap_pend <= 1'b0;
                        end else if (r_slot != LAST_SLOT) begin
                            r_slot <= r_slot + SLOT_W'(1);
                        end else begin
                            // trailing slot closes the LED
                            if (s_led_done) begin
                                r_led_pos    <= '0;
                                r_frame_open <= 1'b0;
                            end else begin
                                r_led_pos <= r_led_pos + POS_W'(1);
                            end
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Payload: GRB shifts out MSB first; zeros shift in, so slots past the
    // 24 color bits carry the zero code.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_COLOR && s_color_done) begin
            r_grb <= s_grb;
        end else if (s_load) begin
            if (r_gap_pend) begin
                r_pulse_code  <= '0;
                r_reset_gap   <= 1'b1;
                r_last_of_led <= 1'b0;
                r_frame_done  <= 1'b0;
            end else if (r_slot != LAST_SLOT) begin
                r_pulse_code  <= r_grb[alfe_pkg::GRB_W-1] ? r_code_one : r_code_zero;
                r_reset_gap   <= 1'b0;
                r_last_of_led <= 1'b0;
                r_frame_done  <= 1'b0;
                r_grb         <= {r_grb[alfe_pkg::GRB_W-2:0], 1'b0};
            end else begin
                r_pulse_code  <= '0;
                r_reset_gap   <= 1'b0;
                r_last_of_led <= 1'b1;
                r_frame_done  <= s_led_done;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pulse_code  = r_pulse_code;
    assign o_reset_gap   = r_reset_gap;
    assign o_last_of_led = r_last_of_led;
    assign o_frame_done  = r_frame_done;

endmodule

@@ tb/sv/tb_addressable_led_frame_encoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_addressable_led_frame_encoder_unit
// Self-checking bench for the LED frame encoder. LED color words go in over
// valid/ready. A local color and slot model predicts every slot word, and
// each word taken from the output is compared with the oldest prediction.
// The run has a directed table, then random phases that use different
// register settings and different idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_addressable_led_frame_encoder_unit;

    localparam int unsigned MAX_LEDS     = 1024;
    localparam int unsigned BITS_PER_LED = 24;

    localparam int unsigned IDX_W  = alfe_pkg::CFG_IDX_W;
    localparam int unsigned DATA_W = alfe_pkg::CFG_DATA_W;

    localparam int unsigned RESET_SLOTS_RST = 230;
    localparam int unsigned RAMP_DIV        = 15360;  // 60 * 256

    // indexes that decode to no register
    localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd4;
    localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;  // long sink hold-off
    localparam int SETTLE_CYCLES = 40;   // quiet time at the end, catches stray words

    // one expected slot word
    typedef struct packed {
        logic [15:0] code;
        logic        gap;
        logic        last;
        logic        done;
    } t_slot_word;

    // directed row: the color word, and the G,R,B value where it is obvious
    typedef struct packed {
        alfe_pkg::t_led_item word;
        logic                known;
        logic [23:0]         grb;
    } t_led_case;

    localparam int DIRECTED_ROWS     = 24;
    localparam int DIRECTED_RECONFIG = 4;  // rows before this use reset settings

    localparam t_led_case LED_CASES [DIRECTED_ROWS] = '{
        // reset settings: full white, black, zero brightness, saturated brightness
        '{'{alfe_pkg::CMD_PACKED, 24'hFFFFFF, 9'd0,   9'd256}, 1'b1, 24'hFFFFFF},
        '{'{alfe_pkg::CMD_PACKED, 24'h000000, 9'd0,   9'd256}, 1'b1, 24'h000000},
        '{'{alfe_pkg::CMD_PACKED, 24'hFFFFFF, 9'd0,   9'd0},   1'b1, 24'h000000},
        '{'{alfe_pkg::CMD_PACKED, 24'hFFFFFF, 9'd0,   9'd511}, 1'b1, 24'hFFFFFF},
        // one-LED frames from here on; channel order is G, R, B
        '{'{alfe_pkg::CMD_PACKED, 24'hA5C3F0, 9'd0,   9'd257}, 1'b1, 24'hC3A5F0},
        '{'{alfe_pkg::CMD_PACKED, 24'h00FF00, 9'd511, 9'd256}, 1'b1, 24'hFF0000},
        '{'{alfe_pkg::CMD_PACKED, 24'h123456, 9'd0,   9'd128}, 1'b0, 24'h000000},
        // sector starts of the hue wheel
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd0,   9'd256}, 1'b1, 24'h00FF00},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd60,  9'd256}, 1'b1, 24'hFFFF00},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd120, 9'd256}, 1'b1, 24'hFF0000},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd180, 9'd256}, 1'b1, 24'hFF00FF},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd240, 9'd256}, 1'b1, 24'h0000FF},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd300, 9'd256}, 1'b1, 24'h00FFFF},
        // mid-sector ramps
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd359, 9'd256}, 1'b0, 24'h000000},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd30,  9'd100}, 1'b0, 24'h000000},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd90,  9'd511}, 1'b0, 24'h000000},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd150, 9'd200}, 1'b0, 24'h000000},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd210, 9'd1},   1'b0, 24'h000000},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd270, 9'd255}, 1'b0, 24'h000000},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd330, 9'd256}, 1'b0, 24'h000000},
        // dark and out-of-range hues
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd359, 9'd0},   1'b1, 24'h000000},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd360, 9'd256}, 1'b1, 24'h000000},
        '{'{alfe_pkg::CMD_HUE,    24'hFFFFFF, 9'd400, 9'd256}, 1'b1, 24'h000000},
        '{'{alfe_pkg::CMD_HUE,    24'h000000, 9'd511, 9'd511}, 1'b1, 24'h000000}
    };

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [IDX_W-1:0]      i_cfg_index    = '0;
    logic [DATA_W-1:0]     i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd          = 1'b0;
    logic [23:0]           i_packed_color = '0;
    logic [8:0]            i_hue_angle    = '0;
    logic [8:0]            i_brightness   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [15:0]           o_pulse_code;
    logic                  o_reset_gap;
    logic                  o_last_of_led;
    logic                  o_frame_done;

    addressable_led_frame_encoder_unit #(
        .MAX_LEDS     (MAX_LEDS),
        .BITS_PER_LED (BITS_PER_LED)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_packed_color (i_packed_color),
        .i_hue_angle    (i_hue_angle),
        .i_brightness   (i_brightness),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pulse_code   (o_pulse_code),
        .o_reset_gap    (o_reset_gap),
        .o_last_of_led  (o_last_of_led),
        .o_frame_done   (o_frame_done)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model state: register shadows and frame tracking
    // ------------------------------------------------------------------------
    logic [15:0] code_one_q    = alfe_pkg::CODE_ONE_RST;
    logic [15:0] code_zero_q   = alfe_pkg::CODE_ZERO_RST;
    logic [10:0] led_count_q   = alfe_pkg::LED_COUNT_RST;
    int unsigned frame_pos     = 0;
    bit          frame_open    = 1'b0;

    t_slot_word slots_due [$];  // predicted words, oldest first

    int mismatches    = 0;
    int cycle_count   = 0;
    int out_stall_pct = 0;  // sink stall rate, percent
    int hold_requests = 0;  // bumped by the stimulus to ask for a long hold
    int hold_served   = 0;
    int hold_left     = 0;

    // Brightness-scaled color as {G, R, B}.
    function automatic logic [23:0] scaled_grb(input alfe_pkg::t_led_item w);
        int unsigned lvl, red, grn, blu, sector, t, full, rise, fall;
        lvl = (w.brightness > alfe_pkg::BRIGHT_FULL) ? 32'(alfe_pkg::BRIGHT_FULL)
                                                     : 32'(w.brightness);
        red = 0;
        grn = 0;
        blu = 0;
        if (w.cmd == alfe_pkg::CMD_PACKED) begin
            red = (32'(w.packed_color[23:16]) * lvl) >> 8;
            grn = (32'(w.packed_color[15:8]) * lvl) >> 8;
            blu = (32'(w.packed_color[7:0]) * lvl) >> 8;
        end else if (w.hue_angle < alfe_pkg::HUE_LIMIT) begin
            // six linear sectors; t is the offset inside the sector
            sector = 32'(w.hue_angle) / 32'(alfe_pkg::HUE_SECTOR);
            t      = 32'(w.hue_angle) - sector * 32'(alfe_pkg::HUE_SECTOR);
            full   = (255 * lvl) >> 8;
            rise   = (255 * t * lvl) / RAMP_DIV;
            fall   = (255 * (32'(alfe_pkg::HUE_SECTOR) - t) * lvl) / RAMP_DIV;
            case (sector)
                0:       begin red = full; grn = rise; blu = 0;    end
                1:       begin red = fall; grn = full; blu = 0;    end
                2:       begin red = 0;    grn = full; blu = rise; end
                3:       begin red = 0;    grn = fall; blu = full; end
                4:       begin red = rise; grn = 0;    blu = full; end
                default: begin red = full; grn = 0;    blu = fall; end
            endcase
        end
        // hue past the wheel stays black
        return {grn[7:0], red[7:0], blu[7:0]};
    endfunction

    // Expand one LED into its slot words and advance the frame position.
    task automatic queue_led_slots(input logic [23:0] grb);
        t_slot_word  w;
        int unsigned frame_len;
        bit          closing;
        if (!frame_open) begin
            w = '{16'd0, 1'b1, 1'b0, 1'b0};
            slots_due.push_back(w);
            frame_open = 1'b1;
        end
        for (int i = 0; i < BITS_PER_LED; i++) begin
            // slots past the 24 color bits send a zero
            if (i < alfe_pkg::GRB_W && grb[alfe_pkg::GRB_W-1-i])
                w = '{code_one_q, 1'b0, 1'b0, 1'b0};
            else
                w = '{code_zero_q, 1'b0, 1'b0, 1'b0};
            slots_due.push_back(w);
        end
        // frame length clamps to 1..MAX_LEDS
        frame_len = 32'(led_count_q);
        if (frame_len == 0) frame_len = 1;
        if (frame_len > MAX_LEDS) frame_len = MAX_LEDS;
        closing = (frame_pos + 1 >= frame_len);
        w = '{16'd0, 1'b0, 1'b1, closing};
        slots_due.push_back(w);
        if (closing) begin
            frame_pos  = 0;
            frame_open = 1'b0;
        end else begin
            frame_pos++;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_slot_word();
        t_slot_word seen, due;
        seen = '{o_pulse_code, o_reset_gap, o_last_of_led, o_frame_done};
        if (slots_due.size() == 0) begin
            flag_mismatch($sformatf("stray word code %0d gap %0b last %0b done %0b",
                seen.code, seen.gap, seen.last, seen.done));
        end else begin
            due = slots_due.pop_front();
            if (seen !== due)
                flag_mismatch($sformatf(
                    "got code %0d gap %0b last %0b done %0b, want %0d %0b %0b %0b",
                    seen.code, seen.gap, seen.last, seen.done,
                    due.code, due.gap, due.last, due.done));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sink: checks each accepted word, then picks ready for the next edge.
    // A long hold, once asked for, is counted down here.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_out_valid && i_out_ready)
            check_slot_word();
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Drive one color word and hold it until taken; predict at acceptance.
    task automatic drive_word(input alfe_pkg::t_led_item w, input bit known,
                              input logic [23:0] grb);
        i_in_valid     <= 1'b1;
        i_cmd          <= w.cmd;
        i_packed_color <= w.packed_color;
        i_hue_angle    <= w.hue_angle;
        i_brightness   <= w.brightness;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        queue_led_slots(known ? grb : scaled_grb(w));
    endtask

    task automatic wait_drained();
        while (slots_due.size() != 0) @(posedge i_clk);
    endtask

    // One register write per edge; the shadow follows at the same edge.
    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            alfe_pkg::REG_CODE_ONE:    code_one_q  = data;
            alfe_pkg::REG_CODE_ZERO:   code_zero_q = data;
            alfe_pkg::REG_RESET_SLOTS: ;  // gap length changes no slot word
            alfe_pkg::REG_LED_COUNT:   led_count_q = data[10:0];
            default: ;  // no such register, write dropped
        endcase
    endtask

    // Reconfigure once the block is idle. A junk write to an unused index
    // goes last and must leave the settings alone.
    task automatic apply_settings(input logic [15:0] one_code, zero_code,
                                  input logic [15:0] gap_slots, frame_leds);
        logic [IDX_W-1:0] spare;
        spare = IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
        wait_drained();
        write_reg(alfe_pkg::REG_CODE_ONE, one_code);
        write_reg(alfe_pkg::REG_CODE_ZERO, zero_code);
        write_reg(alfe_pkg::REG_RESET_SLOTS, gap_slots);
        write_reg(alfe_pkg::REG_LED_COUNT, frame_leds);
        write_reg(spare, DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic alfe_pkg::t_led_item random_word();
        alfe_pkg::t_led_item w;
        w.cmd          = 1'($urandom_range(0, 1));
        w.packed_color = 24'($urandom);
        // mostly on the wheel, some past it
        w.hue_angle    = 9'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 359)
                                                         : $urandom_range(360, 511));
        // mostly in range, some above full scale
        w.brightness   = 9'(($urandom_range(0, 99) < 75) ? $urandom_range(0, 256)
                                                         : $urandom_range(257, 511));
        return w;
    endfunction

    // Random phase: settings, source gap rate, sink stall rate, optional
    // long sink hold while the source keeps pushing.
    task automatic run_phase(input logic [15:0] one_code, zero_code,
                             input logic [15:0] gap_slots, frame_leds,
                             input int gap_pct, stall_pct, input bit long_hold,
                             input int words);
        apply_settings(one_code, zero_code, gap_slots, frame_leds);
        out_stall_pct <= stall_pct;
        if (long_hold) hold_requests <= hold_requests + 1;
        for (int n = 0; n < words; n++) begin
            drive_word(random_word(), 1'b0, 24'h0);
            if (n < words - 1 && $urandom_range(0, 99) < gap_pct) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(0, 99) < gap_pct);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. First rows run on the reset settings inside one long
        // frame; then a zero frame length (acts as one LED) and extreme codes;
        // the next LED closes that frame and each later LED has its own frame.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (i == DIRECTED_RECONFIG) begin
                i_in_valid <= 1'b0;
                apply_settings(16'hFFFF, 16'h0000, 16'd1, 16'd0);
            end
            drive_word(LED_CASES[i].word, LED_CASES[i].known, LED_CASES[i].grb);
        end
        i_in_valid <= 1'b0;

        // no idling, short frames, gap setting of 1023
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'd1023, 16'd3, 0, 0, 1'b0, 16);
        // source gaps; 2047 clamps to the largest frame, so it stays open
        run_phase(16'hFFFF, 16'h0000, 16'd1, 16'd2047, 46, 0, 1'b0, 14);
        // sink stalls; frame of two closes the open frame right away
        run_phase(16'h0000, 16'hFFFF, 16'd1, 16'd2, 0, 46, 1'b0, 14);
        // both sides idle, one-LED frames
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(1, 1023)), 16'd1, 17, 17, 1'b0, 14);
        // back-pressure: sink holds off long while the source keeps offering
        run_phase(alfe_pkg::CODE_ONE_RST, alfe_pkg::CODE_ZERO_RST,
                  16'(RESET_SLOTS_RST), 16'd7, 0, 0, 1'b1, 14);
        // both sides idle, random frame length
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(1, 1023)), 16'($urandom_range(1, 12)),
                  17, 17, 1'b0, 14);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
rtl/alfe_pkg.sv
rtl/alfe_color.sv
rtl/addressable_led_frame_encoder_unit.sv
tb/sv/tb_addressable_led_frame_encoder_unit.sv
